### design/y86fd_pkg.sv
// Shared types and constants for the Y86-64 fetch and decode block.
// Used by the channel interfaces, the decoder and the top level.
package y86fd_pkg;

  localparam int unsigned PC_W      = 12;
  localparam int unsigned NPC_W     = 13;
  localparam int unsigned LEN_W     = 4;
  localparam int unsigned MEM_SIZE  = 4096;
  localparam int unsigned CMP_W     = 17;

  localparam logic [3:0] NO_REG   = 4'hf;
  localparam logic [3:0] REG_MAX  = 4'd14;
  localparam logic [3:0] FN_NONE  = 4'h0;
  localparam logic [3:0] FN_CMOV_MAX   = 4'd6;
  localparam logic [3:0] FN_OP_MAX     = 4'd3;
  localparam logic [3:0] FN_JXX_MAX    = 4'd6;
  localparam logic [3:0] FN_IOTRAP_MAX = 4'd5;

  localparam logic [LEN_W-1:0] LEN_SHORT = 4'd1;
  localparam logic [LEN_W-1:0] LEN_REGS  = 4'd2;
  localparam logic [LEN_W-1:0] LEN_DEST  = 4'd9;
  localparam logic [LEN_W-1:0] LEN_LONG  = 4'd10;

  typedef enum logic [3:0] {
    IC_HALT   = 4'h0,
    IC_NOP    = 4'h1,
    IC_CMOV   = 4'h2,
    IC_IRMOV  = 4'h3,
    IC_RMMOV  = 4'h4,
    IC_MRMOV  = 4'h5,
    IC_OP     = 4'h6,
    IC_JXX    = 4'h7,
    IC_CALL   = 4'h8,
    IC_RET    = 4'h9,
    IC_PUSH   = 4'ha,
    IC_POP    = 4'hb,
    IC_IOTRAP = 4'hc
  } icode_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_INS = 2'd1,
    ST_ADR = 2'd2
  } status_t;

  typedef struct packed {
    logic [3:0]       icode;
    logic [3:0]       ifun;
    logic [3:0]       reg_a;
    logic [3:0]       reg_b;
    logic [63:0]      constant;
    logic [NPC_W-1:0] next_pc;
    status_t          status;
  } decode_t;

endpackage

### design/y86fd_if.sv
// Valid/ready channel interfaces for the fetch request and the decoded result.
// Depends on y86fd_pkg for field widths and the status type.
interface y86fd_fetch_if import y86fd_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PC_W-1:0] pc;
  logic [63:0]     bytes_low;
  logic [15:0]     bytes_high;

  modport source(output valid, pc, bytes_low, bytes_high, input ready);
  modport sink(input valid, pc, bytes_low, bytes_high, output ready);
endinterface

interface y86fd_decoded_if import y86fd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [3:0]       icode;
  logic [3:0]       ifun;
  logic [3:0]       reg_a;
  logic [3:0]       reg_b;
  logic [63:0]      constant;
  logic [NPC_W-1:0] next_pc;
  status_t          status;

  modport source(output valid, icode, ifun, reg_a, reg_b, constant, next_pc, status,
                 input ready);
  modport sink(input valid, icode, ifun, reg_a, reg_b, constant, next_pc, status,
               output ready);
endinterface

### design/y86fd_decode.sv
// Combinational Y86-64 instruction decoder: fields, constant, next PC and status.
// Depends on y86fd_pkg.
module y86fd_decode import y86fd_pkg::*; (
  input  logic [PC_W-1:0] pc,
  input  logic [63:0]     bytes_low,
  input  logic [15:0]     bytes_high,
  output decode_t         result
);

  logic [3:0]       icode;
  logic [3:0]       fn;
  logic [3:0]       ra;
  logic [3:0]       rb;
  logic [63:0]      c_regs;
  logic [63:0]      c_dest;
  logic [3:0]       ifun;
  logic [3:0]       oa;
  logic [3:0]       ob;
  logic [63:0]      k;
  logic [LEN_W-1:0] len;
  logic             ok;
  logic [NPC_W-1:0] npc;

  assign icode  = bytes_low[7:4];
  assign fn     = bytes_low[3:0];
  assign ra     = bytes_low[15:12];
  assign rb     = bytes_low[11:8];
  assign c_regs = {bytes_high, bytes_low[63:16]};
  assign c_dest = {bytes_high[7:0], bytes_low[63:8]};

  always_comb begin
    ifun = FN_NONE;
    oa   = NO_REG;
    ob   = NO_REG;
    k    = '0;
    len  = LEN_SHORT;
    ok   = 1'b0;
    case (icode_t'(icode))
      IC_HALT, IC_NOP, IC_RET: begin
        ok = (fn == FN_NONE);
      end
      IC_CMOV: begin
        ifun = fn;
        oa   = ra;
        ob   = rb;
        len  = LEN_REGS;
        ok   = (fn <= FN_CMOV_MAX) && (ra <= REG_MAX) && (rb <= REG_MAX);
      end
      IC_IRMOV: begin
        oa  = ra;
        ob  = rb;
        k   = c_regs;
        len = LEN_LONG;
        ok  = (fn == FN_NONE) && (ra == NO_REG) && (rb <= REG_MAX);
      end
      IC_RMMOV, IC_MRMOV: begin
        oa  = ra;
        ob  = rb;
        k   = c_regs;
        len = LEN_LONG;
        ok  = (fn == FN_NONE) && (ra <= REG_MAX);
      end
      IC_OP: begin
        ifun = fn;
        oa   = ra;
        ob   = rb;
        len  = LEN_REGS;
        ok   = (fn <= FN_OP_MAX) && (ra <= REG_MAX) && (rb <= REG_MAX);
      end
      IC_JXX: begin
        ifun = fn;
        k    = c_dest;
        len  = LEN_DEST;
        ok   = (fn <= FN_JXX_MAX);
      end
      IC_CALL: begin
        k   = c_dest;
        len = LEN_DEST;
        ok  = (fn == FN_NONE);
      end
      IC_PUSH, IC_POP: begin
        oa  = ra;
        ob  = rb;
        len = LEN_REGS;
        ok  = (fn == FN_NONE) && (ra <= REG_MAX) && (rb == NO_REG);
      end
      IC_IOTRAP: begin
        ifun = fn;
        ok   = (fn <= FN_IOTRAP_MAX);
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  assign npc = {1'b0, pc} + NPC_W'(len);

  always_comb begin
    result.icode    = icode;
    result.ifun     = ifun;
    result.reg_a    = oa;
    result.reg_b    = ob;
    result.constant = k;
    result.next_pc  = npc;
    if (CMP_W'(npc) > CMP_W'(MEM_SIZE)) begin
      result.status = ST_ADR;
    end else if (!ok) begin
      result.status = ST_INS;
    end else begin
      result.status = ST_OK;
    end
  end

endmodule

### design/y86_instruction_fetch_decode.sv
// Y86-64 fetch-stage decoder: fetch channel in, decoded channel out.
// The fetch channel carries a PC and the ten instruction bytes found there;
// each transaction yields exactly one decoded transaction with icode, ifun,
// register nibbles, the 8-byte constant, the next PC and a status code.
// Unused register fields read as 15 and an unused constant reads as 0.
// An address error, raised when the next PC passes the memory size, takes
// priority over an invalid-instruction status.
// The path is an input register, the decoder logic and an output register:
// an accepted fetch transaction is captured in the input register, decoded,
// and its result is captured in the output register and offered from there.
// One transaction is accepted every cycle while the receiver takes results.
// When the receiver stalls, the output register holds its result and the
// input register holds the next one; the fetch side stalls only when both
// are full. Synchronous reset empties both registers and keeps no other state.
// Depends on y86fd_pkg, the channel interfaces and y86fd_decode.
module y86_instruction_fetch_decode import y86fd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  y86fd_fetch_if.sink      fetch,
  y86fd_decoded_if.source  decoded
);

  logic            s1_valid;
  logic [PC_W-1:0] s1_pc;
  logic [63:0]     s1_lo;
  logic [15:0]     s1_hi;
  logic            s1_ready;
  decode_t         dec;
  logic            out_valid;
  decode_t         out_data;

  assign s1_ready    = !out_valid || decoded.ready;
  assign fetch.ready = !s1_valid || s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (fetch.ready) begin
      s1_valid <= fetch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fetch.ready && fetch.valid) begin
      s1_pc <= fetch.pc;
      s1_lo <= fetch.bytes_low;
      s1_hi <= fetch.bytes_high;
    end
  end

  y86fd_decode u_decode (
    .pc         (s1_pc),
    .bytes_low  (s1_lo),
    .bytes_high (s1_hi),
    .result     (dec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s1_valid) begin
      out_data <= dec;
    end
  end

  assign decoded.valid    = out_valid;
  assign decoded.icode    = out_data.icode;
  assign decoded.ifun     = out_data.ifun;
  assign decoded.reg_a    = out_data.reg_a;
  assign decoded.reg_b    = out_data.reg_b;
  assign decoded.constant = out_data.constant;
  assign decoded.next_pc  = out_data.next_pc;
  assign decoded.status   = out_data.status;

`ifndef SYNTHESIS
  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_ready) |=> s1_valid)
    else $error("input stage lost a pending transaction");

  a_adr_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.status == ST_ADR) ==
                   (CMP_W'(out_data.next_pc) > CMP_W'(MEM_SIZE))))
    else $error("address error status disagrees with next PC");

  a_unknown_icode: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.icode > IC_IOTRAP) |->
      (out_data.reg_a == NO_REG && out_data.reg_b == NO_REG &&
       out_data.constant == '0 && out_data.status != ST_OK))
    else $error("unknown icode decoded with live fields or ok status");

  a_output_advances: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_ready) |=> out_valid)
    else $error("decoded transaction dropped between stages");
`endif

endmodule

### verif/y86fd_decode_checker.sv
// Checker for the Y86-64 fetch and decode block: predicts each decoded transaction
// from the accepted fetch transactions and compares the results field by field.
// Depends on y86fd_pkg and the channel interfaces in y86fd_if.
module y86fd_decode_checker import y86fd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  y86fd_fetch_if      fetch,
  y86fd_decoded_if    decoded,
  output int unsigned outstanding,
  output int unsigned mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  decode_t     pending_decodes[$];
  int unsigned fail_tally = 0;
  int unsigned queued = 0;

  assign mismatches  = fail_tally;
  assign outstanding = queued;

  function automatic decode_t predict_decode(logic [PC_W-1:0] at, logic [63:0] lo,
                                             logic [15:0] hi);
    decode_t          d;
    logic [3:0]       fn;
    logic [3:0]       ra;
    logic [3:0]       rb;
    logic [LEN_W-1:0] len;
    logic             legal;
    logic [NPC_W-1:0] npc;
    d.icode    = lo[7:4];
    fn         = lo[3:0];
    ra         = lo[15:12];
    rb         = lo[11:8];
    d.ifun     = FN_NONE;
    d.reg_a    = NO_REG;
    d.reg_b    = NO_REG;
    d.constant = '0;
    len        = LEN_SHORT;
    legal      = 1'b0;
    case (d.icode)
      IC_HALT, IC_NOP, IC_RET: begin
        legal = (fn == FN_NONE);
      end
      IC_CMOV: begin
        d.ifun  = fn;
        d.reg_a = ra;
        d.reg_b = rb;
        len     = LEN_REGS;
        legal   = (fn <= FN_CMOV_MAX) && (ra <= REG_MAX) && (rb <= REG_MAX);
      end
      IC_IRMOV: begin
        d.reg_a    = ra;
        d.reg_b    = rb;
        d.constant = {hi, lo[63:16]};
        len        = LEN_LONG;
        legal      = (fn == FN_NONE) && (ra == NO_REG) && (rb <= REG_MAX);
      end
      IC_RMMOV, IC_MRMOV: begin
        d.reg_a    = ra;
        d.reg_b    = rb;
        d.constant = {hi, lo[63:16]};
        len        = LEN_LONG;
        legal      = (fn == FN_NONE) && (ra <= REG_MAX);
      end
      IC_OP: begin
        d.ifun  = fn;
        d.reg_a = ra;
        d.reg_b = rb;
        len     = LEN_REGS;
        legal   = (fn <= FN_OP_MAX) && (ra <= REG_MAX) && (rb <= REG_MAX);
      end
      IC_JXX: begin
        d.ifun     = fn;
        d.constant = {hi[7:0], lo[63:8]};
        len        = LEN_DEST;
        legal      = (fn <= FN_JXX_MAX);
      end
      IC_CALL: begin
        d.constant = {hi[7:0], lo[63:8]};
        len        = LEN_DEST;
        legal      = (fn == FN_NONE);
      end
      IC_PUSH, IC_POP: begin
        d.reg_a = ra;
        d.reg_b = rb;
        len     = LEN_REGS;
        legal   = (fn == FN_NONE) && (ra <= REG_MAX) && (rb == NO_REG);
      end
      IC_IOTRAP: begin
        d.ifun = fn;
        legal  = (fn <= FN_IOTRAP_MAX);
      end
      default: begin
        legal = 1'b0;
      end
    endcase
    npc       = NPC_W'(at) + NPC_W'(len);
    d.next_pc = npc;
    if (npc > MEM_SIZE) begin
      d.status = ST_ADR;
    end else if (!legal) begin
      d.status = ST_INS;
    end else begin
      d.status = ST_OK;
    end
    return d;
  endfunction

  task automatic check_field(string field, logic [63:0] want, logic [63:0] seen);
    if (want !== seen) begin
      $error("%s mismatch: expected %0h, got %0h", field, want, seen);
      fail_tally++;
    end
  endtask

  always @(posedge clk) begin : track
    decode_t want;
    if (rst) begin
      pending_decodes.delete();
    end else begin
      if (decoded.valid && decoded.ready) begin
        if (pending_decodes.size() == 0) begin
          $error("Decoded transaction arrived with no fetch transaction outstanding.");
          fail_tally++;
        end else begin
          want = pending_decodes.pop_front();
          check_field("icode", 64'(want.icode), 64'(decoded.icode));
          check_field("ifun", 64'(want.ifun), 64'(decoded.ifun));
          check_field("reg_a", 64'(want.reg_a), 64'(decoded.reg_a));
          check_field("reg_b", 64'(want.reg_b), 64'(decoded.reg_b));
          check_field("constant", want.constant, decoded.constant);
          check_field("next_pc", 64'(want.next_pc), 64'(decoded.next_pc));
          check_field("status", 64'(want.status), 64'(decoded.status));
        end
      end
      if (fetch.valid && fetch.ready) begin
        pending_decodes.push_back(predict_decode(fetch.pc, fetch.bytes_low, fetch.bytes_high));
      end
    end
    queued <= pending_decodes.size();
  end

endmodule

### verif/tb.sv
// Top of the testbench for the Y86-64 fetch and decode block: clock, reset,
// fetch stimulus, receiver back-pressure and the final verdict.
// Depends on y86fd_pkg, the channel interfaces and y86fd_decode_checker.
module tb;
  import y86fd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] IC_UNDEF_LO = 4'hd;
  localparam logic [3:0] IC_UNDEF_HI = 4'hf;
  localparam int unsigned RANDOM_PER_PHASE = 283;
  localparam int unsigned HOLD_CYCLES      = 80;

  logic        clk = 1'b0;
  logic        rst;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_req = 1'b0;
  logic        hold_taken = 1'b0;
  int unsigned outstanding;
  int unsigned mismatches;

  y86fd_fetch_if   fetch();
  y86fd_decoded_if decoded();

  y86_instruction_fetch_decode i_dut (
    .clk     (clk),
    .rst     (rst),
    .fetch   (fetch),
    .decoded (decoded)
  );

  y86fd_decode_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .fetch       (fetch),
    .decoded     (decoded),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  always #5ns clk = ~clk;

  initial begin
    #2ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    decoded.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        decoded.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        decoded.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_fetch(input logic [PC_W-1:0] at, input logic [63:0] lo,
                            input logic [15:0] hi);
    while ($urandom_range(99) < send_idle_pct) begin
      fetch.valid <= 1'b0;
      @(posedge clk);
    end
    fetch.valid      <= 1'b1;
    fetch.pc         <= at;
    fetch.bytes_low  <= lo;
    fetch.bytes_high <= hi;
    @(posedge clk);
    while (!fetch.ready) @(posedge clk);
  endtask

  task automatic send_insn(input logic [PC_W-1:0] at, input logic [3:0] ic,
                           input logic [3:0] fn, input logic [3:0] ra, input logic [3:0] rb);
    logic [63:0] lo;
    lo       = {$urandom, $urandom};
    lo[15:0] = {ra, rb, ic, fn};
    send_fetch(at, lo, 16'($urandom));
  endtask

  task automatic wait_for_decodes();
    fetch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [3:0] fn_limit(logic [3:0] ic);
    case (ic)
      IC_CMOV:   return FN_CMOV_MAX;
      IC_OP:     return FN_OP_MAX;
      IC_JXX:    return FN_JXX_MAX;
      IC_IOTRAP: return FN_IOTRAP_MAX;
      default:   return FN_NONE;
    endcase
  endfunction

  function automatic logic [PC_W-1:0] pick_pc();
    if ($urandom_range(99) < 15) return PC_W'($urandom_range(MEM_SIZE - 1, MEM_SIZE - 16));
    return PC_W'($urandom_range(MEM_SIZE - 1));
  endfunction

  // Mostly well-formed instructions with random operands, some fully random bytes.
  task automatic random_fetch();
    logic [3:0] ic;
    logic [3:0] fn;
    logic [3:0] ra;
    logic [3:0] rb;
    if ($urandom_range(99) < 20) begin
      send_fetch(PC_W'($urandom_range(MEM_SIZE - 1)), {$urandom, $urandom}, 16'($urandom));
    end else begin
      if ($urandom_range(99) < 90) begin
        ic = 4'($urandom_range(IC_IOTRAP));
      end else begin
        ic = 4'($urandom_range(IC_UNDEF_HI, IC_UNDEF_LO));
      end
      fn = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(fn_limit(ic)));
      if ($urandom_range(3) == 0) begin
        ra = 4'($urandom);
        rb = 4'($urandom);
      end else begin
        ra = (ic == IC_IRMOV) ? NO_REG : 4'($urandom_range(REG_MAX));
        rb = (ic == IC_PUSH || ic == IC_POP) ? NO_REG : 4'($urandom_range(REG_MAX));
      end
      send_insn(pick_pc(), ic, fn, ra, rb);
    end
  endtask

  initial begin
    rst              <= 1'b1;
    fetch.valid      <= 1'b0;
    fetch.pc         <= '0;
    fetch.bytes_low  <= '0;
    fetch.bytes_high <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_fetch('0, '0, '0);
    send_fetch('1, '1, '1);
    send_insn(12'd1, IC_NOP, FN_NONE, NO_REG, NO_REG);
    send_insn(12'd2, IC_HALT, FN_NONE + 4'd1, NO_REG, NO_REG);
    send_insn(12'd3, IC_CMOV, FN_CMOV_MAX, 4'd0, REG_MAX);
    send_insn(12'd5, IC_CMOV, FN_CMOV_MAX + 4'd1, 4'd1, 4'd2);
    send_insn(12'd7, IC_CMOV, FN_NONE, 4'd3, NO_REG);
    send_insn(12'd9, IC_IRMOV, FN_NONE, NO_REG, 4'd0);
    send_insn(12'd19, IC_IRMOV, FN_NONE, 4'd3, 4'd4);
    send_insn(12'd29, IC_RMMOV, FN_NONE, REG_MAX, NO_REG);
    send_insn(12'd39, IC_MRMOV, FN_NONE, NO_REG, 4'd5);
    send_insn(12'd49, IC_OP, FN_OP_MAX, 4'd6, 4'd7);
    send_insn(12'd51, IC_OP, FN_OP_MAX + 4'd1, 4'd8, 4'd9);
    send_insn(12'd53, IC_JXX, FN_JXX_MAX, 4'd0, 4'd0);
    send_insn(12'd62, IC_JXX, FN_JXX_MAX + 4'd1, 4'd0, 4'd0);
    send_insn(12'd71, IC_CALL, FN_NONE, 4'd0, 4'd0);
    send_insn(12'd80, IC_CALL, FN_NONE + 4'd2, 4'd0, 4'd0);
    send_insn(12'd89, IC_RET, FN_NONE, 4'd0, 4'd0);
    send_insn(12'd90, IC_PUSH, FN_NONE, 4'd4, NO_REG);
    send_insn(12'd92, IC_POP, FN_NONE, 4'd10, 4'd0);
    send_insn(12'd94, IC_IOTRAP, FN_IOTRAP_MAX, 4'd0, 4'd0);
    send_insn(12'd95, IC_IOTRAP, FN_IOTRAP_MAX + 4'd1, 4'd0, 4'd0);
    send_insn(12'd96, IC_UNDEF_LO, FN_NONE, 4'd0, 4'd0);
    send_insn(PC_W'(MEM_SIZE - 10), IC_IRMOV, FN_NONE, NO_REG, 4'd1);
    send_insn(PC_W'(MEM_SIZE - 9), IC_IRMOV, FN_NONE, NO_REG, 4'd1);
    send_insn(PC_W'(MEM_SIZE - 1), IC_OP, 4'hf, 4'd1, 4'd2);
    send_insn(PC_W'(MEM_SIZE - 1), IC_UNDEF_HI - 4'd1, FN_NONE, 4'd0, 4'd0);
    wait_for_decodes();

    send_idle_pct <= 21;
    recv_idle_pct <= 71;
    repeat (RANDOM_PER_PHASE) random_fetch();
    wait_for_decodes();

    send_idle_pct <= 71;
    recv_idle_pct <= 21;
    repeat (RANDOM_PER_PHASE) random_fetch();
    wait_for_decodes();

    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    hold_req      <= 1'b1;
    repeat (RANDOM_PER_PHASE) random_fetch();
    wait_for_decodes();

    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### y86_instruction_fetch_decode.f
design/y86fd_pkg.sv
design/y86fd_if.sv
design/y86fd_decode.sv
design/y86_instruction_fetch_decode.sv
verif/y86fd_decode_checker.sv
verif/tb.sv
